>>> rtl/core/lph_pkg.sv
// ============================================================================
// Linear probe hash table package
// Operation codes, status codes and fixed field widths shared by the block.
// ============================================================================
`default_nettype none

package lph_pkg;

    // Operation field.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    // Status field of a result.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // The reported slot index is always this wide.
    localparam int SLOT_W = 4;

endpackage : lph_pkg

`default_nettype wire

>>> rtl/core/lph_req_if.sv
// ============================================================================
// Linear probe hash table request channel
// Valid/ready channel that carries one table operation per request.
// ============================================================================
`default_nettype none

interface lph_req_if #(
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
);
    logic                      valid;
    logic                      ready;
    logic [lph_pkg::OP_W-1:0]  operation;
    logic [KEY_BITS-1:0]       key;
    logic [PAYLOAD_BITS-1:0]   payload;

    modport source (output valid, output operation, output key, output payload,
                    input ready);
    modport sink   (input valid, input operation, input key, input payload,
                    output ready);
endinterface : lph_req_if

`default_nettype wire

>>> rtl/core/lph_rsp_if.sv
// ============================================================================
// Linear probe hash table response channel
// Valid/ready channel that carries the result of one table operation.
// ============================================================================
`default_nettype none

interface lph_rsp_if #(
    parameter int PAYLOAD_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic [lph_pkg::STATUS_W-1:0]  status;
    logic [lph_pkg::SLOT_W-1:0]    slot;
    logic [PAYLOAD_BITS-1:0]       found_payload;

    modport source (output valid, output status, output slot, output found_payload,
                    input ready);
    modport sink   (input valid, input status, input slot, input found_payload,
                    output ready);
endinterface : lph_rsp_if

`default_nettype wire

>>> rtl/core/linear_probe_hash_table.sv
// ============================================================================
// Linear probe hash table
// Open addressing hash table with linear probing, one operation per request.
// ============================================================================
// Usage:
// Requests arrive on the req channel (operation, key, payload) and each one
// produces exactly one response on the rsp channel (status, slot,
// found_payload). The block works on one request at a time; req.ready is high
// only while the block is idle.
// Steps from an accepted request to a valid response:
//   home slot: the low key bits when TABLE_SIZE is a power of two, else
//   a reciprocal multiply for the quotient, then a multiply and subtract;
//   probe: one RAM read per cycle, the registered
//   read port of the entry RAM setting the pace;
//   output: the result is loaded into the response register once it is free.
// The block returns to idle with that load and takes the next request in the
// cycle after. After reset the block sweeps the entry RAM once to clear every
// valid bit, one slot per cycle; no request is taken during the sweep. The
// response register holds a result until rsp.ready; a new request may be
// accepted meanwhile, and its result waits until the register is free.
// ============================================================================
`default_nettype none

module linear_probe_hash_table #(
    parameter int TABLE_SIZE   = 16,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    lph_req_if.sink  req,
    lph_rsp_if.source rsp
);

    localparam int  IDX_W    = $clog2(TABLE_SIZE);
    localparam int  CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int  KEXT_W   = (KEY_BITS > IDX_W) ? KEY_BITS : IDX_W;
    localparam int  ENTRY_W  = 1 + KEY_BITS + PAYLOAD_BITS;
    localparam bit  IS_POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam int  SHIFT    = KEY_BITS + IDX_W;
    localparam int  RCP_W    = KEY_BITS + 1;
    localparam int  PROD_W   = KEY_BITS + RCP_W;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(TABLE_SIZE - 1);
    localparam logic [KEXT_W-1:0] MOD_DIV  = KEXT_W'(TABLE_SIZE);
    // Rounded-up reciprocal of the table size; exact quotient for every key.
    localparam logic [RCP_W-1:0]  RECIP    =
        RCP_W'(((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Control registers.
    logic [2:0]                      state_reg,     state_next;
    logic [IDX_W-1:0]                iss_pos_reg,   iss_pos_next;
    logic [CNT_W-1:0]                iss_cnt_reg,   iss_cnt_next;
    logic                            chk_vld_reg,   chk_vld_next;
    logic [CNT_W-1:0]                chk_cnt_reg,   chk_cnt_next;
    logic                            mod_step_reg,  mod_step_next;
    logic                            rsp_valid_reg, rsp_valid_next;

    // Data registers.
    logic [lph_pkg::OP_W-1:0]        op_reg,        op_next;
    logic [KEY_BITS-1:0]             key_reg,       key_next;
    logic [PAYLOAD_BITS-1:0]         pay_reg,       pay_next;
    logic [KEY_BITS-1:0]             quo_reg,       quo_next;
    logic [IDX_W-1:0]                chk_pos_reg,   chk_pos_next;
    logic [lph_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [IDX_W-1:0]                res_slot_reg,  res_slot_next;
    logic [PAYLOAD_BITS-1:0]         res_found_reg, res_found_next;
    logic [lph_pkg::STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [lph_pkg::SLOT_W-1:0]      rsp_slot_reg,  rsp_slot_next;
    logic [PAYLOAD_BITS-1:0]         rsp_found_reg, rsp_found_next;

    // Entry RAM signals.
    logic                            ram_wr_en;
    logic [IDX_W-1:0]                ram_wr_addr;
    logic [ENTRY_W-1:0]              ram_wr_data;
    logic                            ram_rd_en;
    logic [ENTRY_W-1:0]              ram_rd_data;

    // Datapath helpers.
    logic [KEXT_W-1:0]               key_ext;
    logic [PROD_W-1:0]               mod_prod;
    logic [KEY_BITS-1:0]             mod_quo;
    logic [KEXT_W-1:0]               mod_rem;
    logic                            rd_valid;
    logic [KEY_BITS-1:0]             rd_key;
    logic [PAYLOAD_BITS-1:0]         rd_pay;
    logic                            chk_hit;
    logic                            chk_last;
    logic                            issue;
    logic                            req_fire;

    // Each entry holds a valid bit, the key and the payload.
    lph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (iss_pos_reg),
        .rd_data (ram_rd_data)
    );

    // Handshake and response ports.
    assign req.ready         = (state_reg == S_IDLE);
    assign req_fire          = req.valid && req.ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.slot          = rsp_slot_reg;
    assign rsp.found_payload = rsp_found_reg;

    // Remainder unit: quotient by reciprocal multiply, then key minus quotient times size.
    assign key_ext  = KEXT_W'(req.key);
    assign mod_prod = key_reg * RECIP;
    assign mod_quo  = KEY_BITS'(mod_prod >> SHIFT);
    assign mod_rem  = KEXT_W'(key_reg) - KEXT_W'(quo_reg) * MOD_DIV;

    // Compare unit on the entry read in the previous cycle.
    assign rd_valid = ram_rd_data[ENTRY_W-1];
    assign rd_key   = ram_rd_data[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
    assign rd_pay   = ram_rd_data[PAYLOAD_BITS-1:0];
    assign chk_hit  = chk_vld_reg &&
                      ((op_reg == lph_pkg::OP_INSERT) ? !rd_valid
                                                      : (rd_valid && (rd_key == key_reg)));
    assign chk_last = chk_vld_reg && (chk_cnt_reg == CNT_LAST);
    assign issue    = (state_reg == S_PROBE) && (iss_cnt_reg != CNT_FULL) && !chk_hit;

    // Entry RAM access: clearing sweep, probe reads and the final write.
    always_comb
    begin
        ram_rd_en   = issue;
        ram_wr_en   = 1'b0;
        ram_wr_addr = chk_pos_reg;
        ram_wr_data = {(op_reg != lph_pkg::OP_DELETE), key_reg, pay_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = iss_pos_reg;
            ram_wr_data = '0;
        end
        else if (chk_hit && (op_reg != lph_pkg::OP_SEARCH))
        begin
            ram_wr_en = 1'b1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        iss_pos_next    = iss_pos_reg;
        iss_cnt_next    = iss_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_cnt_next    = chk_cnt_reg;
        mod_step_next   = mod_step_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        quo_next        = quo_reg;
        chk_pos_next    = chk_pos_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_found_next  = res_found_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        case (state_reg)
            S_CLEAR:
            begin
                iss_pos_next = iss_pos_reg + 1'b1;
                if (iss_pos_reg == LAST_IDX)
                begin
                    iss_pos_next = '0;
                    state_next   = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next       = req.operation;
                    key_next      = req.key;
                    pay_next      = req.payload;
                    iss_cnt_next  = '0;
                    chk_cnt_next  = '0;
                    mod_step_next = 1'b0;
                    iss_pos_next  = key_ext[IDX_W-1:0];
                    state_next    = IS_POW2 ? S_PROBE : S_MOD;
                end
            end

            S_MOD:
            begin
                // Forms the quotient, then the remainder from it.
                if (!mod_step_reg)
                begin
                    quo_next      = mod_quo;
                    mod_step_next = 1'b1;
                end
                else
                begin
                    iss_pos_next  = mod_rem[IDX_W-1:0];
                    mod_step_next = 1'b0;
                    state_next    = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // Issue the next read while checking the previous one.
                chk_vld_next = issue;
                chk_pos_next = iss_pos_reg;
                if (issue)
                begin
                    iss_pos_next = (iss_pos_reg == LAST_IDX) ? '0 : iss_pos_reg + 1'b1;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    chk_cnt_next = chk_cnt_reg + 1'b1;
                end
                if (chk_hit)
                begin
                    res_status_next = lph_pkg::ST_DONE;
                    res_slot_next   = chk_pos_reg;
                    res_found_next  = (op_reg == lph_pkg::OP_SEARCH) ? rd_pay : '0;
                    state_next      = S_OUT;
                end
                else if (chk_last)
                begin
                    res_status_next = (op_reg == lph_pkg::OP_INSERT) ? lph_pkg::ST_FULL
                                                                     : lph_pkg::ST_NOT_FOUND;
                    res_slot_next   = '0;
                    res_found_next  = '0;
                    state_next      = S_OUT;
                end
            end

            S_OUT:
            begin
                // Hand the result over once the response register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = lph_pkg::SLOT_W'(res_slot_reg);
                    rsp_found_next  = res_found_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            iss_pos_reg   <= '0;
            iss_cnt_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            chk_cnt_reg   <= '0;
            mod_step_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_pos_reg   <= iss_pos_next;
            iss_cnt_reg   <= iss_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            chk_cnt_reg   <= chk_cnt_next;
            mod_step_reg  <= mod_step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request, result and response data.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        quo_reg        <= quo_next;
        chk_pos_reg    <= chk_pos_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_found_reg  <= res_found_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_found_reg  <= rsp_found_next;
    end

    // An accepted request closes the request channel until its result is staged.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request accepted while another one is in progress");

    // A new response only ever comes from the output step.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg && rsp_valid_next) |-> (state_reg == S_OUT))
        else $error("response raised outside the output step");

    // Only an insert can report a full table.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && (res_status_reg == lph_pkg::ST_FULL))
            |-> (op_reg == lph_pkg::OP_INSERT))
        else $error("full status on a lookup");

    // The table changes only during the sweep or on a probe hit.
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == S_CLEAR) || ((state_reg == S_PROBE) && chk_hit)))
        else $error("entry RAM written outside sweep or hit");

    // A returned payload implies a successful operation.
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.found_payload != '0)) |-> (rsp.status == lph_pkg::ST_DONE))
        else $error("payload returned with a failing status");

endmodule : linear_probe_hash_table

`default_nettype wire

>>> rtl/core/lph_ram.sv
// ============================================================================
// Linear probe hash table RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : lph_ram

`default_nettype wire

>>> verif/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps
// ============================================================================
// Linear probe hash table testbench
// Sends insert, search, update and delete requests through the request
// channel and predicts every response from a shadow copy of the table. The
// response channel is checked in order, field by field. Directed requests
// cover empty-table misses, home-slot collisions with wraparound, duplicate
// keys and holes left by deletes. Random traffic fills and drains the table
// and runs long mixes over clustered key pools. Both channels stall at random.
// ============================================================================

module tb_linear_probe_hash_table;

    localparam int TABLE_SIZE   = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int OP_W         = lph_pkg::OP_W;
    localparam int POOL_SIZE    = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 25;

    // One response as the block reports it.
    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::SLOT_W-1:0]   slot;
        logic [PAYLOAD_BITS-1:0]      found_payload;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lph_req_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) req_ch ();
    lph_rsp_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) rsp_ch ();

    linear_probe_hash_table #(
        .TABLE_SIZE   (TABLE_SIZE),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table; key and payload read only where valid is set.
    bit                    shadow_valid [TABLE_SIZE] = '{default: 1'b0};
    bit [KEY_BITS-1:0]     shadow_key [TABLE_SIZE] = '{default: '0};
    bit [PAYLOAD_BITS-1:0] shadow_payload [TABLE_SIZE] = '{default: '0};

    table_result_t     awaited_results[$];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    int  mismatch_count  = 0;
    int  cycle_count     = 0;
    int  rsp_hold_cycles = 0;
    bit  sender_idles    = 1'b1;
    bit  receiver_idles  = 1'b1;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one operation to the shadow table and returns its response.
    function automatic table_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                     input logic [KEY_BITS-1:0] key,
                                                     input logic [PAYLOAD_BITS-1:0] payload);
        table_result_t res;
        int pos;
        int hit;
        res = '{status: lph_pkg::ST_NOT_FOUND, slot: '0, found_payload: '0};
        hit = -1;
        pos = key % TABLE_SIZE;
        // Probe every slot from home, wrapping at the end of the table.
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            if (hit < 0)
            begin
                if (op == lph_pkg::OP_INSERT ? !shadow_valid[pos]
                                             : (shadow_valid[pos] && shadow_key[pos] == key))
                    hit = pos;
            end
            pos = (pos + 1) % TABLE_SIZE;
        end
        if (hit < 0)
        begin
            if (op == lph_pkg::OP_INSERT)
                res.status = lph_pkg::ST_FULL;
        end
        else
        begin
            res.status = lph_pkg::ST_DONE;
            res.slot   = hit[lph_pkg::SLOT_W-1:0];
            case (op)
                lph_pkg::OP_INSERT:
                begin
                    shadow_valid[hit]   = 1'b1;
                    shadow_key[hit]     = key;
                    shadow_payload[hit] = payload;
                end
                lph_pkg::OP_SEARCH: res.found_payload = shadow_payload[hit];
                lph_pkg::OP_UPDATE: shadow_payload[hit] = payload;
                lph_pkg::OP_DELETE: shadow_valid[hit] = 1'b0;
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic int table_occupancy();
        int count;
        count = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            count += shadow_valid[i];
        return count;
    endfunction

    // Key of a random occupied slot, or a random key when the table is empty.
    function automatic logic [KEY_BITS-1:0] pick_stored_key();
        int start;
        int idx;
        start = $urandom_range(0, TABLE_SIZE - 1);
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            idx = (start + n) % TABLE_SIZE;
            if (shadow_valid[idx])
                return shadow_key[idx];
        end
        return KEY_BITS'($urandom());
    endfunction

    // Offers one request, after a random gap when the sender idles, and returns at the edge it is taken.
    // Valid stays high on return, so the next call or a drain must follow.
    task automatic issue_request(input logic [OP_W-1:0] op,
                                 input logic [KEY_BITS-1:0] key,
                                 input logic [PAYLOAD_BITS-1:0] payload);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        req_ch.payload   <= payload;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_results.push_back(apply_table_op(op, key, payload));
    endtask

    // Builds one random request: mostly pool keys and stored keys, some noise.
    task automatic issue_random_request(input int unsigned insert_pct);
        int unsigned roll;
        logic [OP_W-1:0] op;
        logic [KEY_BITS-1:0] key;
        logic [PAYLOAD_BITS-1:0] payload;
        roll = $urandom_range(0, 99);
        payload = $urandom();
        case ($urandom_range(0, 15))
            0: payload = '0;
            1: payload = '1;
            default: ;
        endcase
        if (roll < 5)
        begin
            op  = OP_W'($urandom_range(0, 3));
            key = KEY_BITS'($urandom());
        end
        else if (roll < 5 + insert_pct)
        begin
            op  = lph_pkg::OP_INSERT;
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: op = lph_pkg::OP_SEARCH;
                1: op = lph_pkg::OP_UPDATE;
                default: op = lph_pkg::OP_DELETE;
            endcase
            if (table_occupancy() != 0 && $urandom_range(0, 3) != 0)
                key = pick_stored_key();
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        issue_request(op, key, payload);
    endtask

    // Stops offering requests until every outstanding response has come back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Lookups on a freshly cleared table all miss.
    task automatic test_empty_table();
        issue_request(lph_pkg::OP_SEARCH, 16'h0000, 32'h0000_0000);
        issue_request(lph_pkg::OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(lph_pkg::OP_DELETE, 16'h8000, 32'h5555_5555);
        issue_request(lph_pkg::OP_SEARCH, 16'hFFFF, 32'hAAAA_AAAA);
        wait_for_results();
    endtask

    // Keys sharing home slot 15 wrap to slot 0; duplicates and holes follow.
    task automatic test_probe_collisions();
        issue_request(lph_pkg::OP_INSERT, 16'h000F, 32'hA5A5_A5A5);
        issue_request(lph_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(lph_pkg::OP_INSERT, 16'h001F, 32'h0000_0000);
        issue_request(lph_pkg::OP_INSERT, 16'hFFFF, 32'h1234_5678);
        issue_request(lph_pkg::OP_SEARCH, 16'hFFFF, 32'h0000_0000);
        issue_request(lph_pkg::OP_SEARCH, 16'h002F, 32'h0000_0000);
        issue_request(lph_pkg::OP_UPDATE, 16'hFFFF, 32'h0000_0001);
        issue_request(lph_pkg::OP_SEARCH, 16'hFFFF, 32'h0000_0000);
        issue_request(lph_pkg::OP_DELETE, 16'hFFFF, 32'h0000_0000);
        // The second copy is found past the hole the delete left behind.
        issue_request(lph_pkg::OP_SEARCH, 16'hFFFF, 32'h0000_0000);
        issue_request(lph_pkg::OP_INSERT, 16'h7FF0, 32'h5A5A_5A5A);
        issue_request(lph_pkg::OP_DELETE, 16'h001F, 32'h0000_0000);
        issue_request(lph_pkg::OP_SEARCH, 16'h001F, 32'h0000_0000);
        issue_request(lph_pkg::OP_DELETE, 16'hFFFF, 32'h0000_0000);
        issue_request(lph_pkg::OP_DELETE, 16'h000F, 32'h0000_0000);
        issue_request(lph_pkg::OP_DELETE, 16'h7FF0, 32'h0000_0000);
        wait_for_results();
    endtask

    // Fills every slot, tries one insert too many, then deletes everything.
    task automatic test_fill_and_drain();
        logic [3:0] home;
        logic [KEY_BITS-1:0] key;
        home = 4'($urandom_range(0, 15));
        while (table_occupancy() < TABLE_SIZE)
        begin
            key = KEY_BITS'($urandom());
            // About half the keys share one home slot so probes run long and wrap.
            if ($urandom_range(0, 1) != 0)
                key[3:0] = home;
            issue_request(lph_pkg::OP_INSERT, key, $urandom());
        end
        issue_request(lph_pkg::OP_INSERT, {12'hABC, home}, $urandom());
        issue_request(lph_pkg::OP_SEARCH, pick_stored_key(), $urandom());
        issue_request(lph_pkg::OP_UPDATE, pick_stored_key(), $urandom());
        issue_request(lph_pkg::OP_SEARCH, pick_stored_key(), $urandom());
        issue_request(lph_pkg::OP_SEARCH, KEY_BITS'($urandom()), $urandom());
        while (table_occupancy() != 0)
            issue_request(lph_pkg::OP_DELETE, pick_stored_key(), $urandom());
        issue_request(lph_pkg::OP_SEARCH, {12'hABC, home}, $urandom());
        wait_for_results();
    endtask

    // Long mixes over clustered key pools with varying insert weight and idling.
    task automatic test_random_operations();
        logic [3:0] home_a;
        logic [3:0] home_b;
        int unsigned insert_pct;
        for (int ep = 0; ep < 10; ep++)
        begin
            sender_idles   = ep[0];
            receiver_idles = ep[1];
            insert_pct     = 30 + 15 * (ep % 3);
            home_a = 4'($urandom_range(0, 15));
            home_b = 4'($urandom_range(0, 15));
            // Half the pool clusters on two home slots; the rest is spread out.
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                key_pool[i] = KEY_BITS'($urandom());
                if (i < POOL_SIZE / 2)
                    key_pool[i][3:0] = (i % 2 != 0) ? home_a : home_b;
            end
            for (int n = 0; n < 110; n++)
                issue_random_request(insert_pct);
            if (ep == 4)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // The response side holds off long enough that the request side stalls.
    task automatic test_response_backpressure();
        sender_idles    = 1'b0;
        receiver_idles  = 1'b1;
        rsp_hold_cycles = 80;
        for (int n = 0; n < 12; n++)
            issue_random_request(45);
        wait_for_results();
        sender_idles = 1'b1;
    endtask

    // Response ready: random stalls per response when the receiver idles, or one long hold when asked.
    initial
    begin : rsp_ready_driver
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                stall_left = receiver_idles ? $urandom_range(0, 4) : 0;
            else if (rsp_ch.valid && stall_left != 0)
                stall_left--;
            if (rsp_hold_cycles != 0)
            begin
                rsp_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= (stall_left == 0);
            end
        end
    end

    // Each accepted response is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_responses
        table_result_t got;
        table_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{status: rsp_ch.status, slot: rsp_ch.slot,
                    found_payload: rsp_ch.found_payload};
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: response with no request outstanding: %s %0d %0d %h",
                             $time, "status slot payload",
                             got.status, got.slot, got.found_payload);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.found_payload !== want.found_payload)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: expected status %0d slot %0d payload %h, ",
                                  "got status %0d slot %0d payload %h"},
                                 $time, want.status, want.slot, want.found_payload,
                                 got.status, got.slot, got.found_payload);
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= lph_pkg::OP_SEARCH;
        req_ch.key       <= '0;
        req_ch.payload   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_probe_collisions();
        test_fill_and_drain();
        test_random_operations();
        test_response_backpressure();

        // Let any stray response show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb_linear_probe_hash_table
